/* sv/mi3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse
// Element widths, lane count, divider depth and the result records that the
// lanes and the determinant unit hand to the output stage.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W    = 32;
  localparam int N_ELEM    = 9;
  localparam int N_LANES   = 9;
  localparam int DET_OUT_W = 64;
  // Magnitude of the exact determinant stays below 6 * 2^93.
  localparam int DMAG_W    = 96;
  // Quotient bits resolved by the divider, one per stage.
  localparam int QUO_W     = 32;

  localparam int IN_W   = N_ELEM * ELEM_W;
  localparam int OUT_W  = N_LANES * ELEM_W + DET_OUT_W;
  localparam int USER_W = 2;

  // Bit positions in the result tuser.
  localparam int USER_SINGULAR = 0;
  localparam int USER_SAT      = 1;

  // Element order in the input: a11 a12 a13 a21 a22 a23 a31 a32 a33.
  // Cofactor of lane k is e[p]*e[q] - e[r]*e[s], listed as {p, q, r, s}.
  localparam int COF_IDX [N_LANES][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_t;

  typedef struct packed {
    logic [ELEM_W-1:0] val;
    logic              sat;
  } lane_res_t;

  typedef struct packed {
    logic [DET_OUT_W-1:0] val;
    logic                 sat;
    logic                 zero;
  } det_res_t;

endpackage

/* sv/mi3_det.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det: exact determinant of a 3x3 matrix
// Six triple products by the rule of Sarrus, summed at full precision, then
// split into sign and magnitude. The magnitude is delayed alongside the
// divider stages of the lanes, and the saturated output value is delayed to
// the output stage.
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            en,
  input  mi3_pkg::mat_t                                   a,
  output logic                                            dneg,
  output logic [mi3_pkg::QUO_W:0][mi3_pkg::DMAG_W-1:0]    den_line,
  output mi3_pkg::det_res_t                               res
);
  import mi3_pkg::*;

  logic signed [ELEM_W-1:0] e [N_ELEM];
  logic signed [63:0]       p_r  [6];
  logic signed [31:0]       f_r  [6];
  logic signed [64:0]       lo_r [6];
  logic signed [63:0]       hi_r [6];
  logic signed [96:0]       t_r  [6];
  logic signed [97:0]       x_r, y_r, z_r, z2_r;
  logic signed [98:0]       s_r, det_r;
  logic                     dneg_r, dzero_r;
  logic [DMAG_W-1:0]        dmag_r;
  logic [DMAG_W-1:0]        den_r [1:QUO_W];
  det_res_t                 dres_r [0:QUO_W];
  logic [DMAG_W-1:0]        sh;
  logic [DET_OUT_W-1:0]     lim, mag;
  det_res_t                 dres_nxt;

  for (genvar k = 0; k < N_ELEM; k++) begin : g_elem
    assign e[k] = a[k];
  end

  // Stage 1: first product of each term, keep its third factor.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= e[0] * e[4];  f_r[0] <= e[8];
      p_r[1] <= e[3] * e[7];  f_r[1] <= e[2];
      p_r[2] <= e[6] * e[1];  f_r[2] <= e[5];
      p_r[3] <= e[2] * e[4];  f_r[3] <= e[6];
      p_r[4] <= e[5] * e[7];  f_r[4] <= e[0];
      p_r[5] <= e[8] * e[1];  f_r[5] <= e[3];
    end
  end

  // Stages 2 and 3: 64 by 32 product as two 32-bit partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        lo_r[k] <= $signed({1'b0, p_r[k][31:0]}) * f_r[k];
        hi_r[k] <= $signed(p_r[k][63:32]) * f_r[k];
        t_r[k]  <= $signed({hi_r[k][63], hi_r[k], 32'd0}) + 97'(lo_r[k]);
      end
    end
  end

  // Stages 4 to 6: sum of the three positive and three negative terms.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= 98'(t_r[0]) + 98'(t_r[1]);
      y_r   <= 98'(t_r[2]) - 98'(t_r[3]);
      z_r   <= 98'(t_r[4]) + 98'(t_r[5]);
      s_r   <= 99'(x_r) + 99'(y_r);
      z2_r  <= z_r;
      det_r <= s_r - 99'(z2_r);
    end
  end

  // Stage 7: sign and magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r  <= det_r[98];
      dzero_r <= (det_r == '0);
      dmag_r  <= DMAG_W'(det_r[98] ? -det_r : det_r);
    end
  end

  // Output value of the determinant, truncated and saturated to 64 bits.
  always_comb begin
    sh  = dmag_r >> FRAC_BITS;
    lim = dneg_r ? {1'b1, {(DET_OUT_W-1){1'b0}}} : {1'b0, {(DET_OUT_W-1){1'b1}}};
    dres_nxt.sat = (sh > DMAG_W'(lim));
    mag = dres_nxt.sat ? lim : sh[DET_OUT_W-1:0];
    dres_nxt.val  = dneg_r ? -mag : mag;
    dres_nxt.zero = dzero_r;
  end

  // Delay lines toward the lanes and the output stage.
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[1]  <= dmag_r;
      dres_r[0] <= dres_nxt;
      for (int k = 2; k <= QUO_W; k++) begin
        den_r[k] <= den_r[k-1];
      end
      for (int k = 1; k <= QUO_W; k++) begin
        dres_r[k] <= dres_r[k-1];
      end
    end
  end

  assign den_line[0] = dmag_r;
  for (genvar k = 1; k <= QUO_W; k++) begin : g_den
    assign den_line[k] = den_r[k];
  end

  assign dneg = dneg_r;
  assign res  = dres_r[QUO_W];

endmodule

/* sv/mi3_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_lane: one inverse element
// Computes one cofactor exactly, then divides its magnitude, scaled by the
// fraction bits, by the determinant magnitude in a restoring divider that
// resolves one quotient bit per stage. The last stage saturates to 32 bits.
// ----------------------------------------------------------------------------
module mi3_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         en,
  input  logic [mi3_pkg::ELEM_W-1:0]                   p,
  input  logic [mi3_pkg::ELEM_W-1:0]                   q,
  input  logic [mi3_pkg::ELEM_W-1:0]                   r,
  input  logic [mi3_pkg::ELEM_W-1:0]                   s,
  input  logic                                         dneg,
  input  logic [mi3_pkg::QUO_W:0][mi3_pkg::DMAG_W-1:0] den_line,
  output mi3_pkg::lane_res_t                           res
);
  import mi3_pkg::*;

  localparam int W_NUM = 64 + 2 * FRAC_BITS;
  localparam int W_C   = DMAG_W + QUO_W;

  logic signed [63:0] pq_r, rs_r;
  logic signed [64:0] cof_r;
  logic [63:0]        mag_r [0:4];
  logic               cneg_r [0:4];
  logic [W_NUM-1:0]   rem_r [0:QUO_W];
  logic [QUO_W-1:0]   quo_r [0:QUO_W];
  logic               ovf_r [0:QUO_W];
  logic               neg_r [0:QUO_W];
  logic [W_NUM-1:0]   num;
  logic [QUO_W-1:0]   lim, m;

  // Stages 1 to 3: cofactor, sign and magnitude, then a delay line for both.
  always_ff @(posedge clk) begin
    if (en) begin
      pq_r      <= $signed(p) * $signed(q);
      rs_r      <= $signed(r) * $signed(s);
      cof_r     <= 65'(pq_r) - 65'(rs_r);
      mag_r[0]  <= 64'(cof_r[64] ? -cof_r : cof_r);
      cneg_r[0] <= cof_r[64];
      for (int k = 1; k <= 4; k++) begin
        mag_r[k]  <= mag_r[k-1];
        cneg_r[k] <= cneg_r[k-1];
      end
    end
  end

  // Stage 8: scaled numerator and the check for a quotient of 2^32 or more.
  assign num = {mag_r[4], {(2*FRAC_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      quo_r[0] <= '0;
      ovf_r[0] <= (W_C'(num) >= {den_line[0], {QUO_W{1'b0}}});
      neg_r[0] <= cneg_r[4] ^ dneg;
    end
  end

  // Divider stages, most significant quotient bit first.
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int SH = QUO_W - 1 - j;
    logic [W_C-1:0] trial;
    logic [W_C-1:0] diff;
    logic           ge;

    always_comb begin
      trial = W_C'(den_line[j+1]) << SH;
      ge    = (W_C'(rem_r[j]) >= trial);
      diff  = W_C'(rem_r[j]) - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? diff[W_NUM-1:0] : rem_r[j];
        quo_r[j+1] <= quo_r[j] | (QUO_W'(ge) << SH);
        ovf_r[j+1] <= ovf_r[j];
        neg_r[j+1] <= neg_r[j];
      end
    end
  end

  // Saturate the quotient and apply the sign.
  always_comb begin
    lim = neg_r[QUO_W] ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
    res.sat = ovf_r[QUO_W] || (quo_r[QUO_W] > lim);
    m       = res.sat ? lim : quo_r[QUO_W];
    res.val = neg_r[QUO_W] ? -m : m;
  end

endmodule

/* sv/mi3_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_merge: output stage
// Merges the nine lane results and the determinant into one transaction,
// forces a singular result to zero, and holds it in an output register with
// a skid register behind it so the pipeline can take one more result on a stall.
// ----------------------------------------------------------------------------
module mi3_merge (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            inc_valid,
  input  mi3_pkg::lane_res_t [mi3_pkg::N_LANES-1:0]       lres,
  input  mi3_pkg::det_res_t                               dres,
  output logic                                            pipe_en,
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  output logic [mi3_pkg::OUT_W-1:0]                       out_tdata,
  output logic [mi3_pkg::USER_W-1:0]                      out_tuser
);
  import mi3_pkg::*;

  logic [OUT_W-1:0]  inc_data;
  logic [USER_W-1:0] inc_user;
  logic              any_sat;
  logic              out_vld_r, skid_vld_r;
  logic [OUT_W-1:0]  out_data_r, skid_data_r;
  logic [USER_W-1:0] out_user_r, skid_user_r;
  logic              load_out;

  // Merge the lanes; a singular matrix gives an all-zero result.
  always_comb begin
    any_sat = dres.sat;
    for (int k = 0; k < N_LANES; k++) begin
      any_sat = any_sat | lres[k].sat;
      inc_data[k*ELEM_W +: ELEM_W] = dres.zero ? '0 : lres[k].val;
    end
    inc_data[N_LANES*ELEM_W +: DET_OUT_W] = dres.zero ? '0 : dres.val;
    inc_user[USER_SINGULAR] = dres.zero;
    inc_user[USER_SAT]      = !dres.zero && any_sat;
  end

  assign pipe_en  = !skid_vld_r;
  assign load_out = !out_vld_r || out_tready;

  // Control of the output and skid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (load_out) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (load_out) begin
      out_vld_r <= inc_valid;
    end else if (inc_valid) begin
      skid_vld_r <= 1'b1;
    end
  end

  // Payload of the output and skid registers.
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (load_out) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (load_out) begin
      out_data_r <= inc_data;
      out_user_r <= inc_user;
    end else begin
      skid_data_r <= inc_data;
      skid_user_r <= inc_user;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid register filled without a stalled output");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_user_r[USER_SINGULAR]) |-> (out_data_r == '0 && !out_user_r[USER_SAT]))
    else $error("singular result carries nonzero data or a saturation flag");
`endif

endmodule

/* sv/matrix_inverse_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: pipelined inverse of a 3x3 fixed-point matrix
// Adjugate method with an exact determinant and nine parallel divider lanes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one matrix per transaction, nine signed
//   elements with FRAC_BITS fraction bits. The output channel carries the
//   nine inverse elements, the determinant with 2*FRAC_BITS fraction bits,
//   and the singular and saturated flags in tuser.
//   Throughput is one matrix per cycle while the skid register is empty.
//   A result passes through the determinant stages, the divider setup,
//   32 restoring divider stages (one quotient bit each) and the output
//   register.
//   If the receiver stalls, the skid register takes one more result and
//   in_tready falls in the next cycle; the whole pipeline then holds until
//   the output register drains. Reset empties the pipeline and both output
//   registers; there is no other state.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Fields from bit 0: a11 a12 a13 a21 a22 a23 a31 a32 a33, 32 bits each.
  input  logic [mi3_pkg::IN_W-1:0]          in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: inv11 .. inv33 (32 bits each), determinant (64 bits).
  output logic [mi3_pkg::OUT_W-1:0]         out_tdata,
  // Fields from bit 0: singular, saturated.
  output logic [mi3_pkg::USER_W-1:0]        out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import mi3_pkg::*;

  localparam int LAT = 8 + QUO_W;

  mat_t                              a;
  logic                              en;
  logic [LAT-1:0]                    vld_r;
  logic                              dneg;
  logic [QUO_W:0][DMAG_W-1:0]        den_line;
  det_res_t                          dres;
  lane_res_t [N_LANES-1:0]           lres;

  assign a         = in_tdata;
  assign in_tready = en;

  // Valid bits travel with the data through the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk      (clk),
    .en       (en),
    .a        (a),
    .dneg     (dneg),
    .den_line (den_line),
    .res      (dres)
  );

  // One lane per inverse element, in row order.
  for (genvar k = 0; k < N_LANES; k++) begin : g_lane
    mi3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk      (clk),
      .en       (en),
      .p        (a[COF_IDX[k][0]]),
      .q        (a[COF_IDX[k][1]]),
      .r        (a[COF_IDX[k][2]]),
      .s        (a[COF_IDX[k][3]]),
      .dneg     (dneg),
      .den_line (den_line),
      .res      (lres[k])
    );
  end

  mi3_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .inc_valid  (vld_r[LAT-1]),
    .lres       (lres),
    .dres       (dres),
    .pipe_en    (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* sim/matrix_inverse_3x3_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_test: self-checking bench for the 3x3 matrix inverse
// Streams matrices through the block under random sender gaps and receiver
// stalls, predicts every inverse, determinant and flag pair with exact wide
// arithmetic, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_test;
  import mi3_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_RANDOM = 1930;

  typedef struct packed {
    logic [OUT_W-1:0]  data;
    logic [USER_W-1:0] user;
  } inv_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;

  logic [IN_W-1:0] pending_mats[$];
  inv_res_t expected_inverses[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  bit stim_done = 1'b0;

  matrix_inverse_3x3 #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready)
  );

  always #4 clk = ~clk;

  // Saturate a magnitude with a sign to a signed width.
  function automatic logic [63:0] clip(logic [255:0] mag, bit neg, int w, ref bit sat);
    logic [255:0] lim;
    logic [255:0] m;
    lim = (256'd1 << (w - 1)) - (neg ? 256'd0 : 256'd1);
    if (mag > lim) begin
      sat = 1'b1;
      m = lim;
    end else begin
      m = mag;
    end
    if (neg) m = -m;
    return (w == 64) ? m[63:0] : {32'd0, m[31:0]};
  endfunction

  // Exact adjugate inverse of one matrix.
  function automatic inv_res_t invert_matrix(logic [IN_W-1:0] mat);
    logic signed [255:0] e[9];
    logic signed [255:0] det, cf;
    logic [255:0] dmag, cmag, quo;
    logic [63:0] cv;
    inv_res_t res;
    bit sat;
    bit dneg;
    int p, q, r, s;
    sat = 1'b0;
    res = '0;
    for (int k = 0; k < 9; k++) e[k] = $signed(mat[k*ELEM_W +: ELEM_W]);
    det = e[0]*e[4]*e[8] + e[3]*e[7]*e[2] + e[6]*e[1]*e[5]
        - e[2]*e[4]*e[6] - e[5]*e[7]*e[0] - e[8]*e[1]*e[3];
    if (det == 0) begin
      res.user[USER_SINGULAR] = 1'b1;
      return res;
    end
    dneg = det < 0;
    dmag = dneg ? -det : det;
    for (int k = 0; k < 9; k++) begin
      p = COF_IDX[k][0]; q = COF_IDX[k][1]; r = COF_IDX[k][2]; s = COF_IDX[k][3];
      cf = e[p]*e[q] - e[r]*e[s];
      cmag = (cf < 0) ? -cf : cf;
      quo = (cmag << (2*FRAC)) / dmag;
      cv = clip(quo, (cf < 0) != dneg, 32, sat);
      res.data[k*ELEM_W +: ELEM_W] = cv[31:0];
    end
    res.data[N_LANES*ELEM_W +: DET_OUT_W] = clip(dmag >> FRAC, dneg, 64, sat);
    res.user[USER_SAT] = sat;
    return res;
  endfunction

  function automatic logic [IN_W-1:0] rand_matrix(int kind);
    logic [IN_W-1:0] m;
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0: m[k*32 +: 32] = $urandom;
        1: m[k*32 +: 32] = $urandom_range(0, 1) ? $urandom_range(0, 8) << FRAC
                                              : -($urandom_range(0, 8) << FRAC);
        2: m[k*32 +: 32] = $signed(16'($urandom));
        default: m[k*32 +: 32] = $signed(24'($urandom));
      endcase
    end
    // Sometimes force a singular matrix by copying a row.
    if ($urandom_range(0, 9) == 0) m[6*32 +: 96] = m[0 +: 96];
    return m;
  endfunction

  // Driver: offers pending matrices with random idle cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_inverses.push_back(invert_matrix(in_tdata));
        void'(pending_mats.pop_front());
      end
      if ((!in_tvalid || in_tready)) begin
        if (pending_mats.size() > (in_tvalid && in_tready ? 0 : 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_mats[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls, including a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: checks every output transaction against the oldest prediction.
  always @(posedge clk) begin
    inv_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_inverses.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b", $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        want = expected_inverses.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_tdata[k*32 +: 32] !== want.data[k*32 +: 32]) begin
            $display("%0t: inv%0d%0d expected %h actual %h", $time, k/3+1, k%3+1,
                     want.data[k*32 +: 32], out_tdata[k*32 +: 32]);
            error_count++;
          end
        if (out_tdata[288 +: 64] !== want.data[288 +: 64]) begin
          $display("%0t: determinant expected %h actual %h", $time,
                   want.data[288 +: 64], out_tdata[288 +: 64]);
          error_count++;
        end
        if (out_tuser !== want.user) begin
          $display("%0t: flags expected %b actual %b", $time, want.user, out_tuser);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || stim_done)
      quiet_cycles <= 0;
    else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("matrix_inverse_3x3_test NOT OK");
        $finish;
      end
    end
  end

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < count; n++) pending_mats.push_back(rand_matrix($urandom_range(0, 3)));
    while (pending_mats.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [IN_W-1:0] m;
    int drain;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: identity, zero, extremes, singular, overflow, tiny determinant.
    m = '0;
    m[0 +: 32] = 32'h10000; m[4*32 +: 32] = 32'h10000; m[8*32 +: 32] = 32'h10000;
    pending_mats.push_back(m);
    pending_mats.push_back('0);
    pending_mats.push_back({9{32'h7fffffff}});
    pending_mats.push_back({9{32'h80000000}});
    m = '0;
    m[0 +: 32] = 32'h80000000; m[4*32 +: 32] = 32'h7fffffff; m[8*32 +: 32] = 32'h80000000;
    pending_mats.push_back(m);
    m = '0;
    m[0 +: 32] = 32'h1; m[4*32 +: 32] = 32'h1; m[8*32 +: 32] = 32'h1;
    pending_mats.push_back(m);
    m = '0;
    m[0 +: 32] = 32'h7fffffff; m[4*32 +: 32] = 32'h7fffffff; m[8*32 +: 32] = 32'h7fffffff;
    pending_mats.push_back(m);
    m = '0;
    m[0 +: 32] = 32'hffffffff; m[4*32 +: 32] = 32'h1; m[8*32 +: 32] = 32'h80000000;
    pending_mats.push_back(m);
    m = '0;
    m[2*32 +: 32] = 32'h20000; m[4*32 +: 32] = 32'hfffe0000; m[6*32 +: 32] = 32'h8000;
    pending_mats.push_back(m);
    m = {9{32'hffffffff}};
    m[0 +: 32] = 32'h2;
    pending_mats.push_back(m);
    m = '0;
    m[0 +: 32] = 32'h7fffffff; m[4*32 +: 32] = 32'h80000000; m[8*32 +: 32] = 32'h80000000;
    m[1*32 +: 32] = 32'h7fffffff; m[5*32 +: 32] = 32'h80000000; m[6*32 +: 32] = 32'h7fffffff;
    pending_mats.push_back(m);
    run_phase(0, 0, 0);
    run_phase(0, 0, N_RANDOM / 5);
    run_phase(48, 0, N_RANDOM / 5);
    run_phase(0, 48, N_RANDOM / 5);
    run_phase(12, 12, N_RANDOM / 5);
    // Long receiver hold-off while the sender keeps offering.
    hold_off_cycles = 200;
    run_phase(0, 0, N_RANDOM / 5);
    drain = 0;
    while (expected_inverses.size() > 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    stim_done = 1'b1;
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_inverses.size() == 0) begin
      $display("matrix_inverse_3x3_test OK");
    end else begin
      $display("matrix_inverse_3x3_test NOT OK");
    end
    $finish;
  end
endmodule
